/* design/cgm_pkg.sv */
// ----------------------------------------------------------------------------
// cgm_pkg: shared types and constants for the crosstalk mixture density
// Field widths, datapath widths sized for the largest supported order,
// lane configuration bundles and the 2^-x interpolation table.
// ----------------------------------------------------------------------------
`default_nettype none

package cgm_pkg;

  localparam int MAX_ORDER_DEF = 4;
  localparam int MAX_ORDER_LIM = 15;

  // port fields
  localparam int X_W     = 24;
  localparam int GAIN_W  = 23;
  localparam int NOISE_W = 16;
  localparam int PROB_W  = 16;
  localparam int DENS_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // datapath widths, sized for MAX_ORDER_LIM
  localparam int MU_W    = 28;   // x0 + k*gain
  localparam int D_W     = 29;   // x - mu, signed
  localparam int AD_W    = 28;   // |x - mu|
  localparam int D2_W    = 56;   // (x - mu)^2
  localparam int SQ_W    = 32;   // s^2
  localparam int VAR_W   = 37;   // s0^2 + (k+1)*s1^2
  localparam int SG_W    = 19;   // floor(sqrt(var))
  localparam int WB_W    = 17;   // weight numerator / divisor
  localparam int U_W     = 24;   // t*log2(e), Q8.16
  localparam int E_W     = 31;   // 2^-u, Q.30
  localparam int M_W     = 29;   // e / sqrt(2*pi)
  localparam int G_W     = 31;   // gaussian, Q.24
  localparam int ROOT_STEPS = 19;
  localparam int RCNT_W  = 5;

  // quotient widths of the three divider rows
  localparam int T_QW    = 23;
  localparam int G_QW    = 37;
  localparam int W_QW    = 48;
  localparam int TERM_W  = W_QW;
  localparam int SUM_W   = TERM_W + 4;

  // accept to term out of a lane
  localparam int LANE_LAT = 2 + T_QW + 3 + G_QW + 1 + W_QW;

  localparam logic [16:0] LOG2E_Q16        = 17'd94548;
  localparam logic [31:0] INV_SQRT_2PI_Q32 = 32'd1713444047;
  localparam logic [WB_W-1:0] ONE_Q16      = 17'h10000;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_PEDESTAL = 3'd0;
  localparam reg_idx_t REG_SPACING  = 3'd1;
  localparam reg_idx_t REG_COMMON   = 3'd2;
  localparam reg_idx_t REG_PIXEL    = 3'd3;
  localparam reg_idx_t REG_PROB     = 3'd4;

  typedef struct packed {
    logic signed [MU_W-1:0] mu;
    logic [VAR_W-1:0]       variance;
    logic [WB_W-1:0]        wnum;
    logic [WB_W-1:0]        wden;
  } lane_cfg_t;

  typedef struct packed {
    logic              load;
    logic              root;
    logic [RCNT_W-1:0] rstep;
  } seq_ctl_t;

  // 2^(-i/8) in Q.30
  function automatic logic [E_W-1:0] exp2_tab(input logic [3:0] i);
    logic [E_W-1:0] v;
    case (i)
      4'd0:    v = 31'd1073741824;
      4'd1:    v = 31'd984625594;
      4'd2:    v = 31'd902905651;
      4'd3:    v = 31'd827968132;
      4'd4:    v = 31'd759250125;
      4'd5:    v = 31'd696235434;
      4'd6:    v = 31'd638450708;
      4'd7:    v = 31'd585461881;
      4'd8:    v = 31'd536870912;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* design/crosstalk_gaussian_mixture_pdf.sv */
// ----------------------------------------------------------------------------
// crosstalk_gaussian_mixture_pdf: crosstalk Gaussian mixture density
// Evaluates the weighted sum of MAX_ORDER+1 normalized Gaussians at one
// charge sample per request, one lane of division cells per term.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  in      | in_valid / in_ready   | in_sample_value  (s24, Q16.8)
//  out     | out_valid / out_ready | out_density      (u32, Q8.24, sat.)
//  cfg     | psel/penable/pwrite   | paddr, pwdata, prdata (5 registers)
//
//  One request per cycle while in_ready is high; the delay from accept to
//  out_valid is set by the three bit-per-cell divider rows of each lane.
//  After reset and after every register write the lane constants are
//  rebuilt in the square, load and root steps, with in_ready low.
//  A held result stalls the whole pipe only when the last stage is full;
//  bubbles keep draining and new requests keep entering.
// ----------------------------------------------------------------------------
`default_nettype none

module crosstalk_gaussian_mixture_pdf import cgm_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [X_W-1:0] in_sample_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DENS_W-1:0]     out_density,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  localparam int LANE_N = MAX_ORDER + 1;
  localparam int KCNT_W = $clog2(LANE_N + 1);

  typedef enum logic [3:0] {
    ST_SQ   = 4'b0001,   // square the noise widths
    ST_LOAD = 4'b0010,   // one lane's constants per cycle
    ST_ROOT = 4'b0100,   // sigma, one root bit per cycle in all lanes
    ST_RUN  = 4'b1000
  } seq_st_t;

  // --------------------------------------------------------------------------
  // register file
  // --------------------------------------------------------------------------
  logic signed [X_W-1:0]  ped_r;
  logic [GAIN_W-1:0]      gain_r;
  logic [NOISE_W-1:0]     s0_r, s1_r;
  logic [PROB_W-1:0]      prob_r;
  logic                   cfg_wr;
  reg_idx_t               ridx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ped_r  <= '0;
      gain_r <= GAIN_W'(256);
      s0_r   <= NOISE_W'(256);
      s1_r   <= '0;
      prob_r <= '0;
    end else if (cfg_wr) begin
      unique case (ridx)
        REG_PEDESTAL: ped_r  <= pwdata[X_W-1:0];
        REG_SPACING:  gain_r <= pwdata[GAIN_W-1:0];
        REG_COMMON:   s0_r   <= pwdata[NOISE_W-1:0];
        REG_PIXEL:    s1_r   <= pwdata[NOISE_W-1:0];
        REG_PROB:     prob_r <= pwdata[PROB_W-1:0];
        default: ;   // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_PEDESTAL: prdata = DATA_W'(unsigned'(ped_r));
      REG_SPACING:  prdata = DATA_W'(gain_r);
      REG_COMMON:   prdata = DATA_W'(s0_r);
      REG_PIXEL:    prdata = DATA_W'(s1_r);
      REG_PROB:     prdata = DATA_W'(prob_r);
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // lane constant sequencer
  // mu(k) = x0 + k*gain, var(k) = s0^2 + (k+1)*s1^2,
  // lane 0 weight 65536/(65536-p), lane k weight (p/65536)^k
  // --------------------------------------------------------------------------
  seq_st_t                st_r, st_nxt;
  logic [KCNT_W-1:0]      kcnt_r, kcnt_nxt;
  logic [RCNT_W-1:0]      rcnt_r, rcnt_nxt;
  logic [SQ_W-1:0]        s0sq_r, s0sq_nxt, s1sq_r, s1sq_nxt;
  logic [VAR_W-1:0]       acc_r, acc_nxt;       // k * s1^2
  logic signed [MU_W-1:0] mu_acc_r, mu_acc_nxt;
  logic [WB_W-1:0]        pk_r, pk_nxt, pkn;
  logic                   kzero;
  logic                   busy;
  lane_cfg_t              lcfg;

  assign kzero = (kcnt_r == '0);
  assign pkn   = WB_W'((33'(pk_r) * 33'(prob_r)) >> 16);
  assign busy  = (st_r != ST_RUN);

  assign lcfg.mu       = mu_acc_r;
  assign lcfg.variance = VAR_W'(s0sq_r) + acc_r + VAR_W'(s1sq_r);
  assign lcfg.wnum     = kzero ? ONE_Q16 : pkn;
  assign lcfg.wden     = kzero ? (ONE_Q16 - WB_W'(prob_r)) : ONE_Q16;

  always_comb begin
    st_nxt     = st_r;
    kcnt_nxt   = kcnt_r;
    rcnt_nxt   = rcnt_r;
    s0sq_nxt   = s0sq_r;
    s1sq_nxt   = s1sq_r;
    acc_nxt    = acc_r;
    mu_acc_nxt = mu_acc_r;
    pk_nxt     = pk_r;
    unique case (st_r)
      ST_SQ: begin
        s0sq_nxt   = SQ_W'(s0_r) * SQ_W'(s0_r);
        s1sq_nxt   = SQ_W'(s1_r) * SQ_W'(s1_r);
        acc_nxt    = '0;
        mu_acc_nxt = MU_W'(ped_r);
        pk_nxt     = ONE_Q16;
        kcnt_nxt   = '0;
        st_nxt     = ST_LOAD;
      end
      ST_LOAD: begin
        mu_acc_nxt = mu_acc_r + $signed(MU_W'(gain_r));
        acc_nxt    = acc_r + VAR_W'(s1sq_r);
        if (!kzero) begin
          pk_nxt = pkn;
        end
        kcnt_nxt = kcnt_r + 1'b1;
        if (kcnt_r == KCNT_W'(LANE_N - 1)) begin
          rcnt_nxt = '0;
          st_nxt   = ST_ROOT;
        end
      end
      ST_ROOT: begin
        rcnt_nxt = rcnt_r + 1'b1;
        if (rcnt_r == RCNT_W'(ROOT_STEPS - 1)) begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: ;
      default: st_nxt = ST_SQ;
    endcase
    if (cfg_wr) begin
      st_nxt = ST_SQ;    // any write rebuilds the lanes
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_SQ;
      kcnt_r <= '0;
      rcnt_r <= '0;
    end else begin
      st_r   <= st_nxt;
      kcnt_r <= kcnt_nxt;
      rcnt_r <= rcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0sq_r   <= s0sq_nxt;
    s1sq_r   <= s1sq_nxt;
    acc_r    <= acc_nxt;
    mu_acc_r <= mu_acc_nxt;
    pk_r     <= pk_nxt;
  end

  // --------------------------------------------------------------------------
  // pipeline control: one enable for all lanes; the pipe freezes only when
  // a finished sum meets a held output register
  // --------------------------------------------------------------------------
  logic                  en;
  logic                  in_acc;
  logic [LANE_LAT-1:0]   vld_r, vld_nxt;
  logic                  sum_vld_r;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic                  out_valid_r;
  logic [DENS_W-1:0]     out_density_r, dens_nxt;
  logic                  zero_width;
  logic [TERM_W-1:0]     term_w [LANE_N];

  assign en       = !(sum_vld_r && out_valid_r && !out_ready);
  assign in_ready = en && !busy;
  assign in_acc   = in_valid && in_ready;
  assign vld_nxt  = {vld_r[LANE_LAT-2:0], in_acc};

  for (genvar k = 0; k < LANE_N; k++) begin : g_lane
    seq_ctl_t sc;
    assign sc.load  = (st_r == ST_LOAD) && (kcnt_r == KCNT_W'(k));
    assign sc.root  = (st_r == ST_ROOT);
    assign sc.rstep = rcnt_r;

    cgm_lane u_lane (
      .clk    (clk),
      .en     (en),
      .seq    (sc),
      .cfg    (lcfg),
      .x      (in_sample_value),
      .term_o (term_w[k])
    );
  end

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < LANE_N; k++) begin
      sum_nxt = sum_nxt + SUM_W'(term_w[k]);
    end
  end

  // both widths zero: every sigma is zero, density is infinite
  assign zero_width = (s0_r == '0) && (s1_r == '0);
  assign dens_nxt   = (zero_width || (|sum_r[SUM_W-1:DENS_W])) ? '1 : sum_r[DENS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      sum_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r     <= vld_nxt;
        sum_vld_r <= vld_r[LANE_LAT-1];
      end
      if (sum_vld_r && en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
    if (sum_vld_r && en) begin
      out_density_r <= dens_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_density = out_density_r;

`ifndef SYNTH
  a_wr_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !in_ready)
    else $error("request accepted right after a register write");

  a_out_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(sum_vld_r))
    else $error("out_valid rose without a finished sum");

  a_sq_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SQ && !cfg_wr) |=> (st_r == ST_LOAD))
    else $error("sequencer stuck in square step");
`endif

endmodule

`default_nettype wire

/* design/cgm_div_cell.sv */
// ----------------------------------------------------------------------------
// cgm_div_cell: one restoring long-division step
// Brings in the next dividend bit, subtracts the divisor when it fits and
// shifts the quotient bit into the dividend/quotient word.
// ----------------------------------------------------------------------------
`default_nettype none

module cgm_div_cell #(
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] div,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] nq_i,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] nq_o
);

  logic [DW:0]   r2;
  logic [DW:0]   dif;
  logic          ge;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] nq_r, nq_nxt;

  assign r2  = {rem_i, nq_i[QW-1]};
  assign dif = r2 - {1'b0, div};
  assign ge  = (r2 >= {1'b0, div});

  assign rem_nxt = ge ? dif[DW-1:0] : r2[DW-1:0];
  assign nq_nxt  = {nq_i[QW-2:0], ge};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
    end
  end

  assign rem_o = rem_r;
  assign nq_o  = nq_r;

endmodule

`default_nettype wire

/* design/cgm_div_chain.sv */
// ----------------------------------------------------------------------------
// cgm_div_chain: row of division cells, one quotient bit per cell
// Remainder at entry must be below the divisor; after QW cells the word
// holds the full quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module cgm_div_chain #(
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] div,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] nq_i,
  output logic [QW-1:0] q_o
);

  logic [DW-1:0] rem_w [QW+1];
  logic [QW-1:0] nq_w  [QW+1];

  assign rem_w[0] = rem_i;
  assign nq_w[0]  = nq_i;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    cgm_div_cell #(.DW(DW), .QW(QW)) u_cell (
      .clk   (clk),
      .en    (en),
      .div   (div),
      .rem_i (rem_w[i]),
      .nq_i  (nq_w[i]),
      .rem_o (rem_w[i+1]),
      .nq_o  (nq_w[i+1])
    );
  end

  assign q_o = nq_w[QW];

endmodule

`default_nettype wire

/* design/cgm_lane.sv */
// ----------------------------------------------------------------------------
// cgm_lane: one mixture term
// Distance, square, exponent division, 2^-x interpolation, normalization
// division by sigma and weighting division; sigma found by a serial root.
// ----------------------------------------------------------------------------
`default_nettype none

module cgm_lane import cgm_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  seq_ctl_t               seq,
  input  lane_cfg_t              cfg,
  input  logic signed [X_W-1:0]  x,
  output logic [TERM_W-1:0]      term_o
);

  // lane constants
  logic signed [MU_W-1:0] mu_r;
  logic [VAR_W-1:0]       variance_r;
  logic [WB_W-1:0]        wnum_r, wden_r;
  logic [VAR_W-1:0]       sq_v_r, sq_v_nxt;
  logic [VAR_W:0]         sq_res_r, sq_res_nxt;
  logic [VAR_W:0]         sq_bit, sq_try;
  logic [5:0]             sq_sh;
  logic [SG_W-1:0]        sg;

  assign sq_sh  = 6'(2 * (ROOT_STEPS - 1) - 2 * int'(seq.rstep));
  assign sq_bit = (VAR_W + 1)'(1) << sq_sh;
  assign sq_try = sq_res_r + sq_bit;

  always_comb begin
    sq_v_nxt   = sq_v_r;
    sq_res_nxt = sq_res_r >> 1;
    if ({1'b0, sq_v_r} >= sq_try) begin
      sq_v_nxt   = sq_v_r - sq_try[VAR_W-1:0];
      sq_res_nxt = (sq_res_r >> 1) + sq_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (seq.load) begin
      mu_r       <= cfg.mu;
      variance_r <= cfg.variance;
      wnum_r     <= cfg.wnum;
      wden_r     <= cfg.wden;
      sq_v_r     <= cfg.variance;
      sq_res_r   <= '0;
    end else if (seq.root) begin
      sq_v_r   <= sq_v_nxt;
      sq_res_r <= sq_res_nxt;
    end
  end

  assign sg = sq_res_r[SG_W-1:0];

  // distance and square
  logic signed [D_W-1:0] d;
  logic [AD_W-1:0]       ad_r, ad_nxt;
  logic [D2_W-1:0]       d2_r, d2_nxt;
  logic                  far;
  logic [T_QW-1:0]       far_dly_r;

  assign d      = D_W'(x) - D_W'(mu_r);
  assign ad_nxt = d[D_W-1] ? AD_W'(-d) : AD_W'(d);
  assign d2_nxt = D2_W'(ad_r) * D2_W'(ad_r);
  assign far    = d2_r > D2_W'({variance_r, 7'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      ad_r      <= ad_nxt;
      d2_r      <= d2_nxt;
      far_dly_r <= {far_dly_r[T_QW-2:0], far};
    end
  end

  // t = (d2 << 16) / (2*var); quotient below 2^23 unless far
  logic [T_QW-1:0] t;

  cgm_div_chain #(.DW(VAR_W + 1), .QW(T_QW)) u_div_t (
    .clk   (clk),
    .en    (en),
    .div   ({variance_r, 1'b0}),
    .rem_i (d2_r[VAR_W+7:7]),
    .nq_i  ({d2_r[6:0], 16'b0}),
    .q_o   (t)
  );

  // exponent: u = t*log2(e), e = 2^-u, m = e/sqrt(2*pi)
  logic [U_W-1:0]  u_r, u_nxt;
  logic            z1_r;
  logic [7:0]      n;
  logic [2:0]      idx;
  logic [12:0]     frac;
  logic [E_W-1:0]  ta, tb, e0, e_r, e_nxt;
  logic [26:0]     dtab;
  logic [39:0]     iprod;
  logic [M_W-1:0]  m_r, m_nxt;
  logic [63:0]     mprod;

  assign u_nxt = U_W'((40'(t) * 40'(LOG2E_Q16)) >> 16);
  assign n     = u_r[23:16];
  assign idx   = u_r[15:13];
  assign frac  = u_r[12:0];
  assign ta    = exp2_tab({1'b0, idx});
  assign tb    = exp2_tab(4'({1'b0, idx}) + 4'd1);
  assign dtab  = 27'(ta - tb);
  assign iprod = 40'(dtab) * 40'(frac);
  assign e0    = ta - E_W'(iprod >> 13);
  assign e_nxt = (z1_r || (n >= 8'd31)) ? '0 : (e0 >> n[4:0]);
  assign mprod = 64'(e_r) * 64'(INV_SQRT_2PI_Q32);
  assign m_nxt = M_W'(mprod >> 32);

  always_ff @(posedge clk) begin
    if (en) begin
      u_r  <= u_nxt;
      z1_r <= far_dly_r[T_QW-1];
      e_r  <= e_nxt;
      m_r  <= m_nxt;
    end
  end

  // g = ((m << 8) / sigma) >> 6
  logic [G_QW-1:0] gq;
  logic [G_W-1:0]  g;

  cgm_div_chain #(.DW(SG_W), .QW(G_QW)) u_div_g (
    .clk   (clk),
    .en    (en),
    .div   (sg),
    .rem_i ('0),
    .nq_i  ({m_r, 8'b0}),
    .q_o   (gq)
  );

  assign g = gq[G_QW-1:6];

  // term = g * wnum / wden
  logic [W_QW-1:0] wp_r, wp_nxt;

  assign wp_nxt = W_QW'(g) * W_QW'(wnum_r);

  always_ff @(posedge clk) begin
    if (en) begin
      wp_r <= wp_nxt;
    end
  end

  cgm_div_chain #(.DW(WB_W), .QW(W_QW)) u_div_w (
    .clk   (clk),
    .en    (en),
    .div   (wden_r),
    .rem_i ('0),
    .nq_i  (wp_r),
    .q_o   (term_o)
  );

endmodule

`default_nettype wire
